FILE: sv/gps_pkg.sv
// ----------------------------------------------------------------------------
// gps_pkg
// Shared constants and types for the polar Gaussian sampler pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package gps_pkg;

   localparam int UNIFORM_BITS  = 16;
   localparam int OUT_FRAC_BITS = 12;
   localparam int SAMPLE_W      = 16;

   localparam int LOG_FRAC  = 30;               // log2 fraction bits
   localparam int ROOT_FRAC = 25;               // root fraction bits
   localparam int K_EXP     = 2 * (UNIFORM_BITS - 1);

   localparam int A_W     = UNIFORM_BITS;       // |u - half|, up to 2^(UB-1)
   localparam int SUM_W   = K_EXP;              // accepted sum of squares
   localparam int P_W     = 5;                  // top-bit index of the sum
   localparam int H_W     = 5;                  // half of the even shift
   localparam int MANT_W  = LOG_FRAC + 1;       // normalized mantissa
   localparam int RAD_W   = 62;                 // square root radicand
   localparam int ROOT_W  = RAD_W / 2;          // square root result
   localparam int REM_W   = ROOT_W + 2;         // square root remainder
   localparam int LN2_W   = 27;
   localparam int HI_W    = P_W + LN2_W;
   localparam int YC_W    = LOG_FRAC + LN2_W;
   localparam int LNP_W   = HI_W + LOG_FRAC;    // -log2(s) * ln2, unshifted
   localparam int NUM_SH  = 26;
   localparam int NUM_W   = LNP_W - NUM_SH;     // -2 ln s in Q.30
   localparam int ROOT_SH = 2 * ROOT_FRAC - 2 * 15;
   localparam int NUMER_W = 2 * ROOT_W;         // scaled product plus rounding
   localparam int ROUND_SH = ROOT_FRAC - OUT_FRAC_BITS;
   localparam int DEN_W   = ROOT_W + ROUND_SH;
   localparam int Q_W     = 17;                 // quotient bits, max is 2^15 + 1

   localparam logic [A_W-1:0]   HALF     = A_W'(1) << (UNIFORM_BITS - 1);
   localparam logic [LN2_W-1:0] LN2_Q27  = 27'd93032640;
   localparam logic [P_W-1:0]   K_C      = P_W'(K_EXP);
   localparam logic [Q_W-1:0]   SAT_POS  = Q_W'(32767);
   localparam logic [Q_W-1:0]   SAT_NEG  = Q_W'(32768);

   // payload that rides along every pipeline stage
   typedef struct packed {
      logic             valid;
      logic             neg1;
      logic             neg2;
      logic [A_W-1:0]   a1;
      logic [A_W-1:0]   a2;
      logic [P_W-1:0]   p;
      logic [H_W-1:0]   h;
      logic [RAD_W-1:0] rad_d;
   } side_type;

endpackage

`default_nettype wire

FILE: sv/gps_req_if.sv
// ----------------------------------------------------------------------------
// gps_req_if
// Request channel: one pair of uniform samples.
// ----------------------------------------------------------------------------
`default_nettype none

interface gps_req_if;
   logic                              valid;
   logic                              ready;
   logic [gps_pkg::UNIFORM_BITS-1:0]  uniform_a;
   logic [gps_pkg::UNIFORM_BITS-1:0]  uniform_b;

   modport source (output valid, output uniform_a, output uniform_b, input ready);
   modport sink   (input valid, input uniform_a, input uniform_b, output ready);
endinterface

`default_nettype wire

FILE: sv/gps_rsp_if.sv
// ----------------------------------------------------------------------------
// gps_rsp_if
// Result channel: one normal deviate per beat, last on the second of a pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface gps_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [gps_pkg::SAMPLE_W-1:0] sample;
   logic                               last;

   modport source (output valid, output sample, output last, input ready);
   modport sink   (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

FILE: sv/gaussian_polar_sampler_unit.sv
// ----------------------------------------------------------------------------
// gaussian_polar_sampler_unit
// Marsaglia polar Gaussian sampler: uniform pair in, two deviates out.
// ----------------------------------------------------------------------------
//  channel   dir   payload                    beat
//  req_ch    in    uniform_a, uniform_b       one uniform pair
//  rsp_ch    out   sample (Q4.12), last       one deviate, last on the second
//
//  A pair enters every cycle while the pipeline is not stalled; it passes
//  the front, log, square roots, scale/divide and output register in turn.
//  Rejected pairs leave no beat. An accepted pair leaves as two beats,
//  set by the single-beat result channel.
//  Synchronous reset clears all valid bits; datapath registers are not reset.
//  Backpressure freezes the whole pipeline unless its last stage is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_polar_sampler_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   gps_req_if.sink    req_ch,
   gps_rsp_if.source  rsp_ch
);

   logic                         pipe_en;
   gps_pkg::side_type            fr_side, lg_side, sq_side, pipe_side;
   logic [gps_pkg::MANT_W-1:0]   fr_mant;
   logic [gps_pkg::NUM_W-1:0]    lg_num;
   logic [gps_pkg::ROOT_W-1:0]   sq_root, sq_d;
   logic [gps_pkg::SAMPLE_W-1:0] pipe_s1, pipe_s2;

   gps_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (req_ch.valid),
      .uniform_a (req_ch.uniform_a),
      .uniform_b (req_ch.uniform_b),
      .side_out  (fr_side),
      .mant_out  (fr_mant)
   );

   gps_log2 u_log2 (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .side_in  (fr_side),
      .mant_in  (fr_mant),
      .side_out (lg_side),
      .num_out  (lg_num)
   );

   gps_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .side_in  (lg_side),
      .rad_in   ({{(gps_pkg::RAD_W-gps_pkg::NUM_W-gps_pkg::ROOT_SH){1'b0}},
                  lg_num, {gps_pkg::ROOT_SH{1'b0}}}),
      .side_out (sq_side),
      .root_out (sq_root),
      .dsq_out  (sq_d)
   );

   gps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .side_in  (sq_side),
      .root_in  (sq_root),
      .dsq_in   (sq_d),
      .side_out (pipe_side),
      .sample1  (pipe_s1),
      .sample2  (pipe_s2)
   );

   // output register holds both deviates of a pair
   logic                         obuf_valid_ff, obuf_valid_in;
   logic                         obuf_phase_ff, obuf_phase_in;
   logic [gps_pkg::SAMPLE_W-1:0] smp1_ff, smp2_ff;
   logic                         obuf_free, load;

   always_comb begin
      obuf_free = !obuf_valid_ff || (rsp_ch.ready && obuf_phase_ff);
      pipe_en   = !pipe_side.valid || obuf_free;
      load      = pipe_en && pipe_side.valid;

      obuf_valid_in = obuf_valid_ff;
      obuf_phase_in = obuf_phase_ff;
      if (load) begin
         obuf_valid_in = 1'b1;
         obuf_phase_in = 1'b0;
      end else if (obuf_valid_ff && rsp_ch.ready) begin
         if (obuf_phase_ff) begin
            obuf_valid_in = 1'b0;
         end else begin
            obuf_phase_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obuf_valid_ff <= 1'b0;
         obuf_phase_ff <= 1'b0;
      end else begin
         obuf_valid_ff <= obuf_valid_in;
         obuf_phase_ff <= obuf_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         smp1_ff <= pipe_s1;
         smp2_ff <= pipe_s2;
      end
   end

   assign req_ch.ready  = pipe_en;
   assign rsp_ch.valid  = obuf_valid_ff;
   assign rsp_ch.last   = obuf_phase_ff;
   assign rsp_ch.sample = obuf_phase_ff ? smp2_ff : smp1_ff;

   // first deviate taken: the second is up next
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.ready && !rsp_ch.last) |=> (rsp_ch.valid && rsp_ch.last))
      else $error("second deviate of a pair did not follow");

   // a frozen pipeline keeps its last stage
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(pipe_side.valid))
      else $error("pipeline output changed while stalled");

   // requests only back up behind a pending result
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> rsp_ch.valid)
      else $error("request stalled with no result pending");

endmodule

`default_nettype wire

FILE: sv/gps_front.sv
// ----------------------------------------------------------------------------
// gps_front
// Maps uniforms to magnitudes, squares, rejects and normalizes (3 stages).
// ----------------------------------------------------------------------------
`default_nettype none

module gps_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             en,
   input  wire logic                             in_valid,
   input  wire logic [gps_pkg::UNIFORM_BITS-1:0] uniform_a,
   input  wire logic [gps_pkg::UNIFORM_BITS-1:0] uniform_b,
   output gps_pkg::side_type                     side_out,
   output logic [gps_pkg::MANT_W-1:0]            mant_out
);

   gps_pkg::side_type s1_in, s1_ff, s2_in, s2_ff, s3_in, s3_ff;
   logic [2*gps_pkg::A_W-1:0]   sq_in;
   logic [gps_pkg::SUM_W-1:0]   sum_ff;
   logic [gps_pkg::P_W-1:0]     p;
   logic [5:0]                  sh6;
   logic [gps_pkg::MANT_W-1:0]  mant_in, mant_ff;

   // stage 1: sign and magnitude of v
   always_comb begin
      s1_in       = '0;
      s1_in.valid = in_valid;
      s1_in.neg1  = ~uniform_a[gps_pkg::UNIFORM_BITS-1];
      s1_in.neg2  = ~uniform_b[gps_pkg::UNIFORM_BITS-1];
      s1_in.a1    = s1_in.neg1 ? gps_pkg::HALF - uniform_a : uniform_a - gps_pkg::HALF;
      s1_in.a2    = s1_in.neg2 ? gps_pkg::HALF - uniform_b : uniform_b - gps_pkg::HALF;
   end

   // stage 2: sum of squares, reject outside (0, 1)
   always_comb begin
      sq_in = {{gps_pkg::A_W{1'b0}}, s1_ff.a1} * {{gps_pkg::A_W{1'b0}}, s1_ff.a1}
            + {{gps_pkg::A_W{1'b0}}, s1_ff.a2} * {{gps_pkg::A_W{1'b0}}, s1_ff.a2};
      s2_in       = s1_ff;
      s2_in.valid = s1_ff.valid && (sq_in != '0)
                    && (sq_in[2*gps_pkg::A_W-1:gps_pkg::SUM_W] == '0);
   end

   // stage 3: top bit, log mantissa and even-shifted radicand
   always_comb begin
      p = '0;
      for (int i = 0; i < gps_pkg::SUM_W; i++) begin
         if (sum_ff[i]) p = gps_pkg::P_W'(i);
      end
      mant_in = {1'b0, sum_ff} << (gps_pkg::K_C - p);
      sh6     = 6'd61 - {1'b0, p};
      s3_in       = s2_ff;
      s3_in.p     = p;
      s3_in.h     = sh6[5:1];
      s3_in.rad_d = {{(gps_pkg::RAD_W-gps_pkg::SUM_W){1'b0}}, sum_ff} << {sh6[5:1], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
         s3_ff.valid <= 1'b0;
      end else if (en) begin
         s1_ff   <= s1_in;
         s2_ff   <= s2_in;
         sum_ff  <= sq_in[gps_pkg::SUM_W-1:0];
         s3_ff   <= s3_in;
         mant_ff <= mant_in;
      end
   end

   assign side_out = s3_ff;
   assign mant_out = mant_ff;

endmodule

`default_nettype wire

FILE: sv/gps_log2.sv
// ----------------------------------------------------------------------------
// gps_log2
// Squaring log2 (one fraction bit per stage), then scale to -2 ln s.
// ----------------------------------------------------------------------------
`default_nettype none

module gps_log2 (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  gps_pkg::side_type                side_in,
   input  wire logic [gps_pkg::MANT_W-1:0]  mant_in,
   output gps_pkg::side_type                side_out,
   output logic [gps_pkg::NUM_W-1:0]        num_out
);

   logic [gps_pkg::MANT_W-1:0]   m_ff  [gps_pkg::LOG_FRAC];
   logic [gps_pkg::LOG_FRAC-1:0] y_ff  [gps_pkg::LOG_FRAC];
   gps_pkg::side_type            sd_ff [gps_pkg::LOG_FRAC];

   for (genvar i = 0; i < gps_pkg::LOG_FRAC; i++) begin : g_rnd
      logic [gps_pkg::MANT_W-1:0]   m_prev, m_in;
      logic [gps_pkg::LOG_FRAC-1:0] y_prev, y_in;
      logic [2*gps_pkg::MANT_W-1:0] sq;
      gps_pkg::side_type            sd_prev;

      if (i == 0) begin : g_first
         assign m_prev  = mant_in;
         assign y_prev  = '0;
         assign sd_prev = side_in;
      end else begin : g_next
         assign m_prev  = m_ff[i-1];
         assign y_prev  = y_ff[i-1];
         assign sd_prev = sd_ff[i-1];
      end

      // square stays in [1, 4); renormalize when it reaches 2
      always_comb begin
         sq   = m_prev * m_prev;
         y_in = y_prev;
         y_in[gps_pkg::LOG_FRAC-1-i] = sq[2*gps_pkg::MANT_W-1];
         if (sq[2*gps_pkg::MANT_W-1]) begin
            m_in = sq[2*gps_pkg::MANT_W-1:gps_pkg::LOG_FRAC+1];
         end else begin
            m_in = sq[2*gps_pkg::MANT_W-2:gps_pkg::LOG_FRAC];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sd_ff[i].valid <= 1'b0;
         end else if (en) begin
            m_ff[i]  <= m_in;
            y_ff[i]  <= y_in;
            sd_ff[i] <= sd_prev;
         end
      end
   end

   gps_pkg::side_type           sa_ff, sb_ff;
   logic [gps_pkg::HI_W-1:0]    hi_in, hi_ff;
   logic [gps_pkg::YC_W-1:0]    yc_in, yc_ff;
   logic [gps_pkg::LNP_W-1:0]   lnp;
   logic [gps_pkg::NUM_W-1:0]   num_ff;

   // -log2(s) * ln2 = (K-p)*ln2*2^30 - y*ln2
   always_comb begin
      hi_in = {{gps_pkg::LN2_W{1'b0}}, gps_pkg::K_C - sd_ff[gps_pkg::LOG_FRAC-1].p}
              * {{gps_pkg::P_W{1'b0}}, gps_pkg::LN2_Q27};
      yc_in = {{gps_pkg::LN2_W{1'b0}}, y_ff[gps_pkg::LOG_FRAC-1]}
              * {{gps_pkg::LOG_FRAC{1'b0}}, gps_pkg::LN2_Q27};
      lnp   = {hi_ff, {gps_pkg::LOG_FRAC{1'b0}}} - {{gps_pkg::P_W{1'b0}}, yc_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_ff.valid <= 1'b0;
         sb_ff.valid <= 1'b0;
      end else if (en) begin
         sa_ff  <= sd_ff[gps_pkg::LOG_FRAC-1];
         hi_ff  <= hi_in;
         yc_ff  <= yc_in;
         sb_ff  <= sa_ff;
         num_ff <= lnp[gps_pkg::LNP_W-1:gps_pkg::NUM_SH];
      end
   end

   assign side_out = sb_ff;
   assign num_out  = num_ff;

endmodule

`default_nettype wire

FILE: sv/gps_isqrt.sv
// ----------------------------------------------------------------------------
// gps_isqrt
// Two-lane floor square root, one root bit per stage.
// Lane 0 takes the log radicand, lane 1 the shifted sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module gps_isqrt (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        en,
   input  gps_pkg::side_type                side_in,
   input  wire logic [gps_pkg::RAD_W-1:0]   rad_in,
   output gps_pkg::side_type                side_out,
   output logic [gps_pkg::ROOT_W-1:0]       root_out,
   output logic [gps_pkg::ROOT_W-1:0]       dsq_out
);

   logic [gps_pkg::RAD_W-1:0]  x_ff  [2][gps_pkg::ROOT_W];
   logic [gps_pkg::REM_W-1:0]  rem_ff[2][gps_pkg::ROOT_W];
   logic [gps_pkg::ROOT_W-1:0] rt_ff [2][gps_pkg::ROOT_W];
   gps_pkg::side_type          sd_ff [gps_pkg::ROOT_W];
   logic [gps_pkg::RAD_W-1:0]  lane_rad [2];

   assign lane_rad[0] = rad_in;
   assign lane_rad[1] = side_in.rad_d;

   for (genvar j = 0; j < gps_pkg::ROOT_W; j++) begin : g_stg
      gps_pkg::side_type sd_prev;

      if (j == 0) begin : g_sd0
         assign sd_prev = side_in;
      end else begin : g_sdn
         assign sd_prev = sd_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sd_ff[j].valid <= 1'b0;
         end else if (en) begin
            sd_ff[j] <= sd_prev;
         end
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [gps_pkg::RAD_W-1:0]  x_prev;
         logic [gps_pkg::REM_W-1:0]  rem_prev, rem_in;
         logic [gps_pkg::ROOT_W-1:0] rt_prev, rt_in;
         logic [gps_pkg::REM_W+1:0]  rin, dif;
         logic [gps_pkg::REM_W-1:0]  test;
         logic                       ge;

         if (j == 0) begin : g_l0
            assign x_prev   = lane_rad[l];
            assign rem_prev = '0;
            assign rt_prev  = '0;
         end else begin : g_ln
            assign x_prev   = x_ff[l][j-1];
            assign rem_prev = rem_ff[l][j-1];
            assign rt_prev  = rt_ff[l][j-1];
         end

         // bring down two radicand bits, try root bit = 1
         always_comb begin
            rin    = {rem_prev, x_prev[gps_pkg::RAD_W-1-2*j -: 2]};
            test   = {rt_prev, 2'b01};
            ge     = rin >= {2'b00, test};
            dif    = rin - {2'b00, test};
            rem_in = ge ? dif[gps_pkg::REM_W-1:0] : rin[gps_pkg::REM_W-1:0];
            rt_in  = {rt_prev[gps_pkg::ROOT_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[l][j]   <= x_prev;
               rem_ff[l][j] <= rem_in;
               rt_ff[l][j]  <= rt_in;
            end
         end
      end
   end

   assign side_out = sd_ff[gps_pkg::ROOT_W-1];
   assign root_out = rt_ff[0][gps_pkg::ROOT_W-1];
   assign dsq_out  = rt_ff[1][gps_pkg::ROOT_W-1];

endmodule

`default_nettype wire

FILE: sv/gps_div.sv
// ----------------------------------------------------------------------------
// gps_div
// Scales both magnitudes by the root, divides by sqrt(S) with rounding,
// one quotient bit per stage, then applies sign and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module gps_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          en,
   input  gps_pkg::side_type                  side_in,
   input  wire logic [gps_pkg::ROOT_W-1:0]    root_in,
   input  wire logic [gps_pkg::ROOT_W-1:0]    dsq_in,
   output gps_pkg::side_type                  side_out,
   output logic [gps_pkg::SAMPLE_W-1:0]       sample1,
   output logic [gps_pkg::SAMPLE_W-1:0]       sample2
);

   gps_pkg::side_type           m1_ff, m2_ff, m3_ff;
   logic [gps_pkg::ROOT_W-1:0]  ap_in [2];
   logic [gps_pkg::ROOT_W-1:0]  ap_ff [2];
   logic [gps_pkg::ROOT_W-1:0]  r_ff, d1_ff, d2_ff;
   logic [gps_pkg::NUMER_W-1:0] prod_ff [2];
   logic [gps_pkg::NUMER_W-1:0] numer_ff[2];
   logic [gps_pkg::DEN_W-1:0]   den_ff;

   // A' = A << h does not exceed sqrt(S << 2h)
   assign ap_in[0] = {{(gps_pkg::ROOT_W-gps_pkg::A_W){1'b0}}, side_in.a1} << side_in.h;
   assign ap_in[1] = {{(gps_pkg::ROOT_W-gps_pkg::A_W){1'b0}}, side_in.a2} << side_in.h;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ff.valid <= 1'b0;
         m2_ff.valid <= 1'b0;
         m3_ff.valid <= 1'b0;
      end else if (en) begin
         m1_ff <= side_in;
         m2_ff <= m1_ff;
         m3_ff <= m2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ap_ff[0] <= ap_in[0];
         ap_ff[1] <= ap_in[1];
         r_ff     <= root_in;
         d1_ff    <= dsq_in;
         for (int l = 0; l < 2; l++) begin
            prod_ff[l]  <= ap_ff[l] * r_ff;
            numer_ff[l] <= prod_ff[l]
                           + ({{(gps_pkg::NUMER_W-gps_pkg::ROOT_W){1'b0}}, d2_ff}
                              << (gps_pkg::ROUND_SH - 1));
         end
         d2_ff  <= d1_ff;
         den_ff <= {d2_ff, {gps_pkg::ROUND_SH{1'b0}}};
      end
   end

   logic [gps_pkg::NUMER_W-1:0] rem_ff [2][gps_pkg::Q_W];
   logic [gps_pkg::Q_W-1:0]     q_ff   [2][gps_pkg::Q_W];
   logic [gps_pkg::DEN_W-1:0]   dv_ff  [gps_pkg::Q_W];
   gps_pkg::side_type           sd_ff  [gps_pkg::Q_W];

   for (genvar j = 0; j < gps_pkg::Q_W; j++) begin : g_stg
      localparam int KB = gps_pkg::Q_W - 1 - j;
      gps_pkg::side_type         sd_prev;
      logic [gps_pkg::DEN_W-1:0] dv_prev;
      logic [gps_pkg::NUMER_W-1:0] dsh;

      if (j == 0) begin : g_s0
         assign sd_prev = m3_ff;
         assign dv_prev = den_ff;
      end else begin : g_sn
         assign sd_prev = sd_ff[j-1];
         assign dv_prev = dv_ff[j-1];
      end

      assign dsh = {{(gps_pkg::NUMER_W-gps_pkg::DEN_W){1'b0}}, dv_prev} << KB;

      always_ff @(posedge clock) begin
         if (reset) begin
            sd_ff[j].valid <= 1'b0;
         end else if (en) begin
            sd_ff[j] <= sd_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[j] <= dv_prev;
         end
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [gps_pkg::NUMER_W-1:0] rem_prev, rem_in;
         logic [gps_pkg::Q_W-1:0]     q_prev, q_in;

         if (j == 0) begin : g_l0
            assign rem_prev = numer_ff[l];
            assign q_prev   = '0;
         end else begin : g_ln
            assign rem_prev = rem_ff[l][j-1];
            assign q_prev   = q_ff[l][j-1];
         end

         always_comb begin
            q_in = q_prev;
            if (rem_prev >= dsh) begin
               rem_in   = rem_prev - dsh;
               q_in[KB] = 1'b1;
            end else begin
               rem_in = rem_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[l][j] <= rem_in;
               q_ff[l][j]   <= q_in;
            end
         end
      end
   end

   logic [gps_pkg::Q_W-1:0] q1, q2, c1, c2, n1, n2;

   // sign and clamp
   always_comb begin
      q1 = q_ff[0][gps_pkg::Q_W-1];
      q2 = q_ff[1][gps_pkg::Q_W-1];
      if (sd_ff[gps_pkg::Q_W-1].neg1) begin
         c1 = (q1 > gps_pkg::SAT_NEG) ? gps_pkg::SAT_NEG : q1;
         n1 = '0 - c1;
      end else begin
         c1 = '0;
         n1 = (q1 > gps_pkg::SAT_POS) ? gps_pkg::SAT_POS : q1;
      end
      if (sd_ff[gps_pkg::Q_W-1].neg2) begin
         c2 = (q2 > gps_pkg::SAT_NEG) ? gps_pkg::SAT_NEG : q2;
         n2 = '0 - c2;
      end else begin
         c2 = '0;
         n2 = (q2 > gps_pkg::SAT_POS) ? gps_pkg::SAT_POS : q2;
      end
      sample1 = n1[gps_pkg::SAMPLE_W-1:0];
      sample2 = n2[gps_pkg::SAMPLE_W-1:0];
   end

   assign side_out = sd_ff[gps_pkg::Q_W-1];

endmodule

`default_nettype wire

FILE: sim/tb_gaussian_polar_sampler_unit.sv
// ----------------------------------------------------------------------------
// tb_gaussian_polar_sampler_unit
// Self-checking bench for the polar Gaussian sampler. Uniform pairs come from
// a queue filled by the stimulus process; a bit-exact fixed-point predictor
// computes the two deviates of every accepted pair, and the monitor compares
// each result beat in order. Idle and stall rates change by phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_gaussian_polar_sampler_unit;

   typedef struct packed {
      logic [gps_pkg::UNIFORM_BITS-1:0] ua;
      logic [gps_pkg::UNIFORM_BITS-1:0] ub;
   } pair_type;

   typedef struct packed {
      logic signed [gps_pkg::SAMPLE_W-1:0] sample;
      logic                                last;
   } deviate_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gps_req_if req_if ();
   gps_rsp_if rsp_if ();

   gaussian_polar_sampler_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   pair_type    pending_pairs[$];
   deviate_type expected_deviates[$];
   int          errors = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          hold_cycles = 0;
   logic        hold_start = 1'b0;
   logic        hold_done = 1'b0;
   longint      cycle_count = 0;

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= r + bitv) begin
            x = x - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return r;
   endfunction

   function automatic logic [15:0] scale_mag(input logic [63:0] mag, input logic neg,
                                             input int hs, input logic [63:0] root,
                                             input logic [63:0] den);
      logic [63:0] q;
      q = (((mag << hs) * root) + (den >> 1)) / den;
      if (neg) begin
         if (q > 32768) q = 32768;
         return 16'((65536 - q) & 64'hFFFF);
      end
      if (q > 32767) q = 32767;
      return q[15:0];
   endfunction

   // queue the deviates of one pair; rejected pairs add nothing
   task automatic predict_deviates(input pair_type pr);
      logic [63:0] a1, a2, s, m, y, l2, num, root, d, den;
      logic        n1, n2;
      int          p, sh;
      deviate_type dv;
      n1 = pr.ua < 16'h8000;
      n2 = pr.ub < 16'h8000;
      a1 = n1 ? 64'h8000 - pr.ua : 64'(pr.ua) - 64'h8000;
      a2 = n2 ? 64'h8000 - pr.ub : 64'(pr.ub) - 64'h8000;
      s = a1 * a1 + a2 * a2;
      if (s == 0 || s >= (64'd1 << gps_pkg::K_EXP)) return;
      p = 0;
      while (p < 63 && (s >> (p + 1)) != 0) p++;
      m = (p >= gps_pkg::LOG_FRAC) ? s >> (p - gps_pkg::LOG_FRAC)
                                   : s << (gps_pkg::LOG_FRAC - p);
      y = 0;
      for (int i = 1; i <= gps_pkg::LOG_FRAC; i++) begin
         m = (m * m) >> gps_pkg::LOG_FRAC;
         if (m >= (64'd1 << (gps_pkg::LOG_FRAC + 1))) begin
            m = m >> 1;
            y = y | (64'd1 << (gps_pkg::LOG_FRAC - i));
         end
      end
      l2 = (64'(gps_pkg::K_EXP - p) << gps_pkg::LOG_FRAC) - y;
      num = (l2 * 64'd93032640) >> 26;
      root = int_sqrt(num << 20);
      sh = (61 - p) & ~1;
      d = int_sqrt(s << sh);
      den = d << (gps_pkg::ROOT_FRAC - gps_pkg::OUT_FRAC_BITS);
      dv.sample = scale_mag(a1, n1, sh >> 1, root, den);
      dv.last = 1'b0;
      expected_deviates.push_back(dv);
      dv.sample = scale_mag(a2, n2, sh >> 1, root, den);
      dv.last = 1'b1;
      expected_deviates.push_back(dv);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid     <= 1'b0;
         req_if.uniform_a <= '0;
         req_if.uniform_b <= '0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_deviates({req_if.uniform_a, req_if.uniform_b});
            void'(pending_pairs.pop_front());
         end
         if ((!req_if.valid || req_if.ready) && pending_pairs.size() > 0 &&
             !(req_if.valid && req_if.ready && pending_pairs.size() == 0) &&
             $urandom_range(99) >= idle_pct) begin
            req_if.valid     <= 1'b1;
            req_if.uniform_a <= pending_pairs[0].ua;
            req_if.uniform_b <= pending_pairs[0].ub;
         end else if (!req_if.valid || req_if.ready) begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus one long hold-off when requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_start && !hold_done) begin
         hold_done    <= 1'b1;
         hold_cycles  <= 300;
         rsp_if.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles  <= hold_cycles - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      deviate_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_deviates.size() == 0) begin
            $display("%0t: unexpected deviate sample=%0d last=%0b",
                     $time, rsp_if.sample, rsp_if.last);
            errors <= errors + 1;
         end else begin
            want = expected_deviates.pop_front();
            if (rsp_if.sample !== want.sample || rsp_if.last !== want.last) begin
               $display("%0t: mismatch expected sample=%0d last=%0b actual sample=%0d last=%0b",
                        $time, want.sample, want.last, rsp_if.sample, rsp_if.last);
               errors <= errors + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > 400000) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic pair_type inner_pair();
      pair_type pr;
      // mostly inside the unit circle, with random radius
      int r;
      r = $urandom_range(15);
      pr.ua = 16'h8000 + 16'($signed($urandom_range(2 * (2 ** r)) - 2 ** r));
      pr.ub = 16'h8000 + 16'($signed($urandom_range(2 * (2 ** r)) - 2 ** r));
      return pr;
   endfunction

   task automatic add_pair(input logic [15:0] a, input logic [15:0] b);
      pair_type pr;
      pr.ua = a;
      pr.ub = b;
      pending_pairs.push_back(pr);
   endtask

   task automatic drain();
      while (pending_pairs.size() > 0 || req_if.valid) @(posedge clock);
      while (expected_deviates.size() > 0) @(posedge clock);
   endtask

   initial begin
      pair_type pr;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: zero, edges, saturation, zero coordinate, rejections
      add_pair(16'h8000, 16'h8000);
      add_pair(16'h0000, 16'h8000);
      add_pair(16'h8000, 16'h0000);
      add_pair(16'h0000, 16'h0000);
      add_pair(16'hFFFF, 16'h8000);
      add_pair(16'h8000, 16'hFFFF);
      add_pair(16'h8001, 16'h8000);
      add_pair(16'h7FFF, 16'h8000);
      add_pair(16'h8000, 16'h7FFF);
      add_pair(16'h8001, 16'h8001);
      add_pair(16'h7FFF, 16'h7FFF);
      add_pair(16'hFFFF, 16'hFFFF);
      add_pair(16'h0001, 16'h8000);
      add_pair(16'hFFFF, 16'h8001);
      add_pair(16'hDA82, 16'hDA82);
      add_pair(16'h257E, 16'h257E);
      add_pair(16'hC000, 16'h4000);
      add_pair(16'h5555, 16'hAAAA);
      add_pair(16'h8002, 16'h7FFE);
      add_pair(16'h8000, 16'h8004);
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct  = (ph == 1) ? 70 : (ph == 3) ? 35 : 0;
         stall_pct = (ph == 2) ? 70 : (ph == 3) ? 35 : 0;
         if (ph == 0) hold_start = 1'b1;
         for (int i = 0; i < 300; i++) begin
            if ($urandom_range(99) < 80) begin
               pr = inner_pair();
            end else begin
               pr.ua = 16'($urandom);
               pr.ub = 16'($urandom);
            end
            pending_pairs.push_back(pr);
         end
         drain();
      end

      repeat (120) @(posedge clock);
      if (errors == 0 && expected_deviates.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
